FILE: hw/rtl/fixed_block_pool_allocator_defines.svh
// Assertion macros for the fixed block pool allocator.
// Used by modules that have clk and rst_n; no other dependencies.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FBPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FBPA_ASSERT(lbl, prop, msg)
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg)
`define FBPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int POOLS      = 4;
    localparam int SLOTS      = 1024;
    localparam int HANDLE_W   = 12;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int POOL_W     = HANDLE_W - SLOT_W;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int LINK_DEPTH = POOLS * SLOTS;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    localparam logic [CNT_W-1:0] HEAD_EMPTY = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OOM       = 2'd1,
        STATUS_UNMANAGED = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

FILE: hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fbpa_ctrl.sv
// Controller for the fixed block pool allocator: accept/execute sequencing
// and output word valid. Depends on fbpa_pkg and the defines header.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output fbpa_pkg::cmd_t cmd
);

    fbpa_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fbpa_pkg::ST_EXEC;
                end
            end
            fbpa_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = fbpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            fbpa_pkg::ST_EXEC:
            begin
                cmd.commit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

    `FBPA_ASSERT_NXT(a_load_exec, cmd.load, state_reg == fbpa_pkg::ST_EXEC, "load did not enter execute")
    `FBPA_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_reg, "commit did not raise out_valid")
    `FBPA_ASSERT(a_excl, !(cmd.load && cmd.commit), "load and commit in one cycle")

endmodule

FILE: hw/rtl/fbpa_datapath.sv
// Datapath for the fixed block pool allocator: pool tables, pool selection,
// link memory and result registers. Depends on fbpa_pkg, fbpa_ram, defines header.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbpa_pkg::cmd_t                  cmd,
    input  logic [1:0]                      action,
    input  logic [fbpa_pkg::HANDLE_W-1:0]   handle,
    output logic [fbpa_pkg::HANDLE_W-1:0]   result_handle,
    output logic                            managed,
    output logic [1:0]                      status
);

    localparam int SUM_W = fbpa_pkg::CNT_W + 1;

    logic [fbpa_pkg::CNT_W-1:0] head_reg   [fbpa_pkg::POOLS];
    logic [fbpa_pkg::CNT_W-1:0] head_next  [fbpa_pkg::POOLS];
    logic [fbpa_pkg::CNT_W-1:0] fresh_reg  [fbpa_pkg::POOLS];
    logic [fbpa_pkg::CNT_W-1:0] fresh_next [fbpa_pkg::POOLS];
    logic [fbpa_pkg::CNT_W-1:0] count_reg  [fbpa_pkg::POOLS];
    logic [fbpa_pkg::CNT_W-1:0] count_next [fbpa_pkg::POOLS];
    logic [fbpa_pkg::POOLS-1:0] active_reg, active_next;

    logic [1:0]                    action_reg;
    logic [fbpa_pkg::HANDLE_W-1:0] handle_reg;

    logic [fbpa_pkg::HANDLE_W-1:0] result_handle_reg, result_handle_next;
    logic                          managed_reg, managed_next;
    logic [1:0]                    status_reg, status_next;

    logic                        found_act, found_free, alloc_ok;
    logic [fbpa_pkg::POOL_W-1:0] sel_act, sel_free, sel;

    logic [SUM_W-1:0]            len_sum;
    logic                        list_nz, list_le1, use_list;
    logic [fbpa_pkg::SLOT_W-1:0] slot_out;

    logic [fbpa_pkg::POOL_W-1:0] rel_pool;
    logic [fbpa_pkg::SLOT_W-1:0] rel_slot;
    logic                        rel_in_range, rel_ok;

    logic                         ram_we, ram_re;
    logic [fbpa_pkg::LINK_AW-1:0] ram_waddr, ram_raddr;
    logic [fbpa_pkg::SLOT_W-1:0]  ram_wdata, ram_rdata;

    // First active pool with room, else first inactive pool
    always_comb
    begin
        found_act  = 1'b0;
        found_free = 1'b0;
        sel_act    = '0;
        sel_free   = '0;
        for (int q = 0; q < fbpa_pkg::POOLS; q++)
        begin
            if (!found_act && active_reg[q] && count_reg[q] != '0)
            begin
                found_act = 1'b1;
                sel_act   = fbpa_pkg::POOL_W'(q);
            end
            if (!found_free && !active_reg[q])
            begin
                found_free = 1'b1;
                sel_free   = fbpa_pkg::POOL_W'(q);
            end
        end
        alloc_ok = found_act || found_free;
        sel      = found_act ? sel_act : sel_free;
    end

    assign len_sum  = {1'b0, count_reg[sel]} + {1'b0, fresh_reg[sel]};
    assign list_nz  = len_sum != SUM_W'(fbpa_pkg::SLOTS);
    assign list_le1 = (len_sum == SUM_W'(fbpa_pkg::SLOTS))
                   || (len_sum == SUM_W'(fbpa_pkg::SLOTS + 1));
    assign use_list = found_act && head_reg[sel] != fbpa_pkg::HEAD_EMPTY && list_nz;

    always_comb
    begin
        if (use_list)
        begin
            slot_out = head_reg[sel][fbpa_pkg::SLOT_W-1:0];
        end
        else if (found_act)
        begin
            slot_out = fresh_reg[sel][fbpa_pkg::SLOT_W-1:0];
        end
        else
        begin
            slot_out = '0;
        end
    end

    assign rel_pool     = handle_reg[fbpa_pkg::HANDLE_W-1:fbpa_pkg::SLOT_W];
    assign rel_slot     = handle_reg[fbpa_pkg::SLOT_W-1:0];
    assign rel_in_range = (fbpa_pkg::POOL_W+1)'(rel_pool) < (fbpa_pkg::POOL_W+1)'(fbpa_pkg::POOLS);
    assign rel_ok       = rel_in_range && active_reg[rel_pool]
                       && count_reg[rel_pool] < fbpa_pkg::CNT_W'(fbpa_pkg::SLOTS);

    // Link read is issued at accept; pool state is unchanged until commit
    assign ram_re    = cmd.load;
    assign ram_raddr = fbpa_pkg::LINK_AW'({sel, head_reg[sel][fbpa_pkg::SLOT_W-1:0]});
    assign ram_waddr = fbpa_pkg::LINK_AW'({rel_pool, rel_slot});
    assign ram_wdata = head_reg[rel_pool][fbpa_pkg::SLOT_W-1:0];

    always_comb
    begin
        head_next          = head_reg;
        fresh_next         = fresh_reg;
        count_next         = count_reg;
        active_next        = active_reg;
        result_handle_next = '0;
        managed_next       = 1'b0;
        status_next        = fbpa_pkg::STATUS_OK;
        ram_we             = 1'b0;
        unique case (fbpa_pkg::action_t'(action_reg))
            fbpa_pkg::ACT_ALLOC:
            begin
                if (!alloc_ok)
                begin
                    status_next = fbpa_pkg::STATUS_OOM;
                end
                else
                begin
                    result_handle_next = fbpa_pkg::HANDLE_W'({sel, slot_out});
                    if (!found_act)
                    begin
                        head_next[sel]   = fbpa_pkg::HEAD_EMPTY;
                        fresh_next[sel]  = fbpa_pkg::CNT_W'(1);
                        count_next[sel]  = fbpa_pkg::CNT_W'(fbpa_pkg::SLOTS - 1);
                        active_next[sel] = 1'b1;
                    end
                    else
                    begin
                        if (use_list)
                        begin
                            head_next[sel] = list_le1 ? fbpa_pkg::HEAD_EMPTY : {1'b0, ram_rdata};
                        end
                        else
                        begin
                            fresh_next[sel] = fresh_reg[sel] + 1'b1;
                        end
                        count_next[sel] = count_reg[sel] - 1'b1;
                    end
                end
            end
            fbpa_pkg::ACT_RELEASE:
            begin
                if (!rel_ok)
                begin
                    status_next = fbpa_pkg::STATUS_UNMANAGED;
                end
                else
                begin
                    ram_we                = cmd.commit && head_reg[rel_pool] != fbpa_pkg::HEAD_EMPTY;
                    head_next[rel_pool]   = {1'b0, rel_slot};
                    count_next[rel_pool]  = count_reg[rel_pool] + 1'b1;
                    active_next[rel_pool] =
                        count_reg[rel_pool] != fbpa_pkg::CNT_W'(fbpa_pkg::SLOTS - 1);
                end
            end
            fbpa_pkg::ACT_CHECK:
            begin
                managed_next = rel_in_range && active_reg[rel_pool];
            end
            default:
            begin
                status_next = fbpa_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < fbpa_pkg::POOLS; q++)
            begin
                head_reg[q]  <= fbpa_pkg::HEAD_EMPTY;
                fresh_reg[q] <= '0;
                count_reg[q] <= fbpa_pkg::CNT_W'(fbpa_pkg::SLOTS);
            end
            active_reg <= fbpa_pkg::POOLS'(1);
        end
        else if (cmd.commit)
        begin
            head_reg   <= head_next;
            fresh_reg  <= fresh_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            handle_reg <= handle;
        end
        if (cmd.commit)
        begin
            result_handle_reg <= result_handle_next;
            managed_reg       <= managed_next;
            status_reg        <= status_next;
        end
    end

    fbpa_ram #(
        .WIDTH (fbpa_pkg::SLOT_W),
        .DEPTH (fbpa_pkg::LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign result_handle = result_handle_reg;
    assign managed       = managed_reg;
    assign status        = status_reg;

    `FBPA_ASSERT_IMP(a_oom_full, !alloc_ok, &active_reg, "no pool chosen while one is inactive")
    `FBPA_ASSERT_IMP(a_list_len, active_reg[sel], len_sum >= SUM_W'(fbpa_pkg::SLOTS), "free list length negative")
    `FBPA_ASSERT_IMP(a_head_list, found_act && head_reg[sel] == fbpa_pkg::HEAD_EMPTY, !list_nz, "empty head with nonempty list")

endmodule

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator top level: one request word in, one result word out.
// Timing: the accepting edge enters the execute state; the result word and out_valid
// are registered when it commits, later while an earlier result word is still stalled.
// Requests: no new request is taken during the execute state, as the link memory
// registered read feeds the pool table update; a stalled output holds the execute cycle.
// Reset: asynchronous active-low rst_n restores all pool tables; the link
// memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module fixed_block_pool_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [fbpa_pkg::HANDLE_W-1:0] handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fbpa_pkg::HANDLE_W-1:0] result_handle,
    output logic                          managed,
    output logic [1:0]                    status
);

    fbpa_pkg::cmd_t cmd;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    fbpa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .handle        (handle),
        .result_handle (result_handle),
        .managed       (managed),
        .status        (status)
    );

endmodule
